// File: sv/hra_pkg.sv
// ----------------------------------------------------------------------------
// hra_pkg
// Shared types, codes and helpers of the heap record allocator.
// ----------------------------------------------------------------------------
package hra_pkg;

	typedef enum logic [2:0] {
		OP_ALLOC_HEAP  = 3'd0,
		OP_ALLOC_STORE = 3'd1,
		OP_FREE        = 3'd2,
		OP_LOCK        = 3'd3,
		OP_UNLOCK      = 3'd4,
		OP_GET_SIZE    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_NO_MEMORY  = 3'd1,
		STATUS_NOT_FOUND  = 3'd2,
		STATUS_HANDLE     = 3'd3,
		STATUS_OUTSIDE    = 3'd4,
		STATUS_NOT_LOCKED = 3'd5,
		STATUS_TABLE_FULL = 3'd6
	} status_t;

	localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
	localparam logic [1:0] REG_HEAP_BYTES  = 2'd1;
	localparam logic [1:0] REG_STORE_BASE  = 2'd2;
	localparam logic [1:0] REG_STORE_BYTES = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] request_bytes;
		logic [31:0] target_address;
		logic        want_handle;
		logic        check_handle;
	} in_word_t;

	typedef struct packed {
		logic [31:0] block_address;
		logic [31:0] block_bytes;
		logic [2:0]  status;
	} out_word_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
	} frag_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// File: sv/hra_ram.sv
// ----------------------------------------------------------------------------
// hra_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hra_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/heap_record_allocator_core.sv
// ----------------------------------------------------------------------------
// heap_record_allocator_core
// Record table and fragment list allocator for a heap and a storage region.
// ----------------------------------------------------------------------------
// One word is handled at a time. Every table entry visited is stepped to, read
// from the synchronous memory and then used, and every entry moved when a
// record or fragment is erased is read and then written back one slot lower.
// A storage allocation needs no table walk. A lookup reads the records in
// order up to the match. A heap allocation first walks
// the record table, then merges fragments pairwise, restarting after each
// merge, so its time grows with the square of the fragment count for each
// merge; it then gives back fragments that end at the heap top and takes the
// first fragment that fits, else the heap top. The result sits in an output
// register, so the next word may be taken while it waits.
// ----------------------------------------------------------------------------
module heap_record_allocator_core #(
	parameter int MAX_RECORDS   = 64,
	parameter int MAX_FRAGMENTS = 32,
	parameter int LOCK_BITS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hra_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output hra_pkg::out_word_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int RIW = $clog2(MAX_RECORDS);
	localparam int RCW = $clog2(MAX_RECORDS + 1);
	localparam int FIW = $clog2(MAX_FRAGMENTS);
	localparam int FCW = $clog2(MAX_FRAGMENTS + 1);

	typedef struct packed {
		logic [31:0]          start;
		logic [31:0]          size;
		logic                 released;
		logic                 handle;
		logic [LOCK_BITS-1:0] locks;
	} rec_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FINISH, ST_S_ALLOC,
		ST_T1_START, ST_T1_NEXT, ST_T1_RD, ST_T1_CHK,
		ST_M_START, ST_M_S_NEXT, ST_M_S_RD, ST_M_S_GET,
		ST_M_C_NEXT, ST_M_C_RD, ST_M_C_CHK,
		ST_R_START, ST_R_NEXT, ST_R_RD, ST_R_CHK,
		ST_A_START, ST_A_NEXT, ST_A_RD, ST_A_CHK,
		ST_L_START, ST_L_NEXT, ST_L_RD, ST_L_CHK,
		ST_F_RD, ST_F_CHK,
		ST_RE_RD, ST_RE_WR, ST_FE_RD, ST_FE_WR
	} state_t;

	state_t state_q, state_d, ret_q, ret_d;
	logic [RCW-1:0] rc_q, rc_d, i_q, i_d, jr_q, jr_d, rc_last;
	logic [FCW-1:0] fc_q, fc_d, s_q, s_d, c_q, c_d, jf_q, jf_d;
	logic [2:0] op_q, op_d;
	logic [32:0] bytes_q, bytes_d, in_bytes;
	logic [31:0] addr_q, addr_d;
	logic wh_q, wh_d, ch_q, ch_d;
	logic [31:0] fs_start_q, fs_start_d, fs_size_q, fs_size_d;
	logic [31:0] heap_base_q, heap_base_d, heap_bytes_q, heap_bytes_d;
	logic [31:0] store_base_q, store_base_d, store_bytes_q, store_bytes_d;
	logic [31:0] heap_top_q, heap_top_d, heap_left_q, heap_left_d;
	logic [31:0] store_top_q, store_top_d, store_left_q, store_left_d;
	logic [31:0] res_addr_q, res_addr_d, res_bytes_q, res_bytes_d;
	logic [2:0] res_status_q, res_status_d;
	logic out_valid_q, out_valid_d;
	hra_pkg::out_word_t out_data_q, out_data_d;

	logic rec_we;
	logic [RIW-1:0] rec_waddr, rec_raddr;
	rec_t rec_wdata, rec_rd;
	logic frag_we;
	logic [FIW-1:0] frag_waddr, frag_raddr;
	hra_pkg::frag_t frag_wdata, frag_rd;

	logic [32:0] fs_end, frag_end, rec_end, region_end;
	logic [RCW-1:0] jr_inc;
	logic [FCW-1:0] jf_inc;

	hra_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_RECORDS)) u_rec_ram (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rd)
	);

	hra_ram #(.WIDTH($bits(hra_pkg::frag_t)), .DEPTH(MAX_FRAGMENTS)) u_frag_ram (
		.clk(clk), .we(frag_we), .waddr(frag_waddr), .wdata(frag_wdata),
		.raddr(frag_raddr), .rdata(frag_rd)
	);

	assign in_bytes   = ({1'b0, in_data.request_bytes} + 33'd1) & ~33'd1;
	assign fs_end     = {1'b0, fs_start_q} + {1'b0, fs_size_q};
	assign frag_end   = {1'b0, frag_rd.start} + {1'b0, frag_rd.size};
	assign rec_end    = {1'b0, rec_rd.start} + {1'b0, rec_rd.size};
	assign region_end = {1'b0, store_base_q} + {1'b0, store_bytes_q};
	assign rc_last    = rc_q - RCW'(1);
	assign jr_inc     = jr_q + RCW'(1);
	assign jf_inc     = jf_q + FCW'(1);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		state_d = state_q; ret_d = ret_q;
		rc_d = rc_q; fc_d = fc_q; i_d = i_q; s_d = s_q; c_d = c_q; jr_d = jr_q; jf_d = jf_q;
		op_d = op_q; bytes_d = bytes_q; addr_d = addr_q; wh_d = wh_q; ch_d = ch_q;
		fs_start_d = fs_start_q; fs_size_d = fs_size_q;
		heap_base_d = heap_base_q; heap_bytes_d = heap_bytes_q;
		store_base_d = store_base_q; store_bytes_d = store_bytes_q;
		heap_top_d = heap_top_q; heap_left_d = heap_left_q;
		store_top_d = store_top_q; store_left_d = store_left_q;
		res_addr_d = res_addr_q; res_bytes_d = res_bytes_q; res_status_d = res_status_q;
		out_valid_d = out_valid_q && out_stall;
		out_data_d = out_data_q;
		rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = '0;
		frag_we = 1'b0; frag_waddr = '0; frag_wdata = '0; frag_raddr = '0;

		if (cfg_we) begin
			case (cfg_index)
				hra_pkg::REG_HEAP_BASE: begin
					heap_base_d = cfg_data; heap_top_d = cfg_data;
				end
				hra_pkg::REG_HEAP_BYTES: begin
					heap_bytes_d = cfg_data; heap_left_d = cfg_data;
				end
				hra_pkg::REG_STORE_BASE: begin
					store_base_d = cfg_data; store_top_d = cfg_data;
				end
				hra_pkg::REG_STORE_BYTES: begin
					store_bytes_d = cfg_data; store_left_d = cfg_data;
				end
				default: begin
				end
			endcase
		end

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d = in_data.op; bytes_d = in_bytes; addr_d = in_data.target_address;
					wh_d = in_data.want_handle; ch_d = in_data.check_handle;
					res_addr_d = '0; res_bytes_d = '0; res_status_d = hra_pkg::STATUS_OK;
					case (in_data.op)
						hra_pkg::OP_ALLOC_HEAP: state_d = ST_T1_START;
						hra_pkg::OP_ALLOC_STORE: state_d = ST_S_ALLOC;
						hra_pkg::OP_FREE, hra_pkg::OP_LOCK, hra_pkg::OP_UNLOCK,
						hra_pkg::OP_GET_SIZE: state_d = ST_L_START;
						default: begin
							res_status_d = hra_pkg::STATUS_NOT_FOUND;
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_data_d.block_address = res_addr_q;
					out_data_d.block_bytes = res_bytes_q;
					out_data_d.status = res_status_q;
					state_d = ST_IDLE;
				end
			end
			ST_S_ALLOC: begin
				if (rc_q >= RCW'(MAX_RECORDS)) begin
					res_status_d = hra_pkg::STATUS_TABLE_FULL;
				end else if (bytes_q > {1'b0, store_left_q}) begin
					res_status_d = hra_pkg::STATUS_NO_MEMORY;
				end else begin
					rec_we = 1'b1; rec_waddr = rc_q[RIW-1:0];
					rec_wdata = '{start: store_top_q, size: bytes_q[31:0], released: 1'b0,
						handle: wh_q, locks: '0};
					rc_d = rc_q + RCW'(1);
					res_addr_d = store_top_q;
					store_top_d = store_top_q + bytes_q[31:0];
					store_left_d = store_left_q - bytes_q[31:0];
				end
				state_d = ST_FINISH;
			end
			ST_T1_START: begin
				i_d = rc_q; state_d = ST_T1_NEXT;
			end
			ST_T1_NEXT: begin
				if (i_q == '0) begin
					state_d = ST_M_START;
				end else begin
					i_d = i_q - RCW'(1); state_d = ST_T1_RD;
				end
			end
			ST_T1_RD: begin
				rec_raddr = i_q[RIW-1:0]; state_d = ST_T1_CHK;
			end
			ST_T1_CHK: begin
				state_d = ST_T1_NEXT;
				if (rec_rd.released) begin
					if (rec_rd.size == '0) begin
						jr_d = i_q; ret_d = ST_T1_NEXT; state_d = ST_RE_RD;
					end else if (fc_q < FCW'(MAX_FRAGMENTS)) begin
						frag_we = 1'b1; frag_waddr = fc_q[FIW-1:0];
						frag_wdata = '{start: rec_rd.start, size: rec_rd.size};
						fc_d = fc_q + FCW'(1);
						jr_d = i_q; ret_d = ST_T1_NEXT; state_d = ST_RE_RD;
					end
				end
			end
			ST_M_START: begin
				s_d = fc_q; state_d = ST_M_S_NEXT;
			end
			ST_M_S_NEXT: begin
				if (s_q == '0) begin
					state_d = ST_R_START;
				end else begin
					s_d = s_q - FCW'(1); state_d = ST_M_S_RD;
				end
			end
			ST_M_S_RD: begin
				frag_raddr = s_q[FIW-1:0]; state_d = ST_M_S_GET;
			end
			ST_M_S_GET: begin
				fs_start_d = frag_rd.start; fs_size_d = frag_rd.size;
				c_d = fc_q; state_d = ST_M_C_NEXT;
			end
			ST_M_C_NEXT: begin
				if (c_q == '0) begin
					state_d = ST_M_S_NEXT;
				end else begin
					c_d = c_q - FCW'(1); state_d = ST_M_C_RD;
				end
			end
			ST_M_C_RD: begin
				if (c_q == s_q) begin
					state_d = ST_M_C_NEXT;
				end else begin
					frag_raddr = c_q[FIW-1:0]; state_d = ST_M_C_CHK;
				end
			end
			ST_M_C_CHK: begin
				if (frag_end == {1'b0, fs_start_q} || fs_end == {1'b0, frag_rd.start}) begin
					frag_we = 1'b1; frag_waddr = s_q[FIW-1:0];
					frag_wdata.start = (frag_rd.start < fs_start_q) ? frag_rd.start : fs_start_q;
					frag_wdata.size = hra_pkg::sat_add(fs_size_q, frag_rd.size);
					jf_d = c_q; ret_d = ST_M_START; state_d = ST_FE_RD;
				end else begin
					state_d = ST_M_C_NEXT;
				end
			end
			ST_R_START: begin
				c_d = fc_q; state_d = ST_R_NEXT;
			end
			ST_R_NEXT: begin
				if (c_q == '0) begin
					state_d = ST_A_START;
				end else begin
					c_d = c_q - FCW'(1); state_d = ST_R_RD;
				end
			end
			ST_R_RD: begin
				frag_raddr = c_q[FIW-1:0]; state_d = ST_R_CHK;
			end
			ST_R_CHK: begin
				if (frag_end == {1'b0, heap_top_q}) begin
					heap_top_d = frag_rd.start;
					heap_left_d = hra_pkg::sat_add(heap_left_q, frag_rd.size);
					jf_d = c_q; ret_d = ST_R_NEXT; state_d = ST_FE_RD;
				end else begin
					state_d = ST_R_NEXT;
				end
			end
			ST_A_START: begin
				if (rc_q >= RCW'(MAX_RECORDS)) begin
					res_status_d = hra_pkg::STATUS_TABLE_FULL; state_d = ST_FINISH;
				end else begin
					c_d = '0; state_d = ST_A_NEXT;
				end
			end
			ST_A_NEXT: begin
				if (c_q == fc_q) begin
					if (bytes_q > {1'b0, heap_left_q}) begin
						res_status_d = hra_pkg::STATUS_NO_MEMORY;
					end else begin
						rec_we = 1'b1; rec_waddr = rc_q[RIW-1:0];
						rec_wdata = '{start: heap_top_q, size: bytes_q[31:0], released: 1'b0,
							handle: wh_q, locks: '0};
						rc_d = rc_q + RCW'(1);
						res_addr_d = heap_top_q;
						heap_top_d = heap_top_q + bytes_q[31:0];
						heap_left_d = heap_left_q - bytes_q[31:0];
					end
					state_d = ST_FINISH;
				end else begin
					state_d = ST_A_RD;
				end
			end
			ST_A_RD: begin
				frag_raddr = c_q[FIW-1:0]; state_d = ST_A_CHK;
			end
			ST_A_CHK: begin
				if ({1'b0, frag_rd.size} >= bytes_q) begin
					rec_we = 1'b1; rec_waddr = rc_q[RIW-1:0];
					rec_wdata = '{start: frag_rd.start, size: bytes_q[31:0], released: 1'b0,
						handle: wh_q, locks: '0};
					rc_d = rc_q + RCW'(1);
					res_addr_d = frag_rd.start;
					frag_we = 1'b1; frag_waddr = c_q[FIW-1:0];
					frag_wdata.start = frag_rd.start + bytes_q[31:0];
					frag_wdata.size = frag_rd.size - bytes_q[31:0];
					if ({1'b0, frag_rd.size} == bytes_q) begin
						jf_d = c_q; ret_d = ST_FINISH; state_d = ST_FE_RD;
					end else begin
						state_d = ST_FINISH;
					end
				end else begin
					c_d = c_q + FCW'(1); state_d = ST_A_NEXT;
				end
			end
			ST_L_START: begin
				if (addr_q < heap_base_q || {1'b0, addr_q} >= region_end) begin
					res_status_d = hra_pkg::STATUS_OUTSIDE; state_d = ST_FINISH;
				end else begin
					i_d = '0; state_d = ST_L_NEXT;
				end
			end
			ST_L_NEXT: begin
				if (i_q == rc_q) begin
					res_status_d = hra_pkg::STATUS_NOT_FOUND; state_d = ST_FINISH;
				end else begin
					state_d = ST_L_RD;
				end
			end
			ST_L_RD: begin
				rec_raddr = i_q[RIW-1:0]; state_d = ST_L_CHK;
			end
			ST_L_CHK: begin
				if (rec_rd.start == addr_q && !rec_rd.released) begin
					state_d = ST_FINISH;
					rec_waddr = i_q[RIW-1:0];
					rec_wdata = rec_rd;
					if (ch_q && (rec_rd.handle != wh_q)) begin
						res_status_d = hra_pkg::STATUS_HANDLE;
					end else begin
						case (op_q)
							hra_pkg::OP_FREE: begin
								rec_we = 1'b1; rec_wdata.released = 1'b1;
								state_d = ST_F_RD;
							end
							hra_pkg::OP_LOCK: begin
								rec_we = 1'b1;
								if (rec_rd.locks != '1) begin
									rec_wdata.locks = rec_rd.locks + LOCK_BITS'(1);
								end
							end
							hra_pkg::OP_UNLOCK: begin
								if (rec_rd.locks != '0) begin
									rec_we = 1'b1;
									rec_wdata.locks = rec_rd.locks - LOCK_BITS'(1);
								end else begin
									res_status_d = hra_pkg::STATUS_NOT_LOCKED;
								end
							end
							default: res_bytes_d = rec_rd.size;
						endcase
					end
				end else begin
					i_d = i_q + RCW'(1); state_d = ST_L_NEXT;
				end
			end
			ST_F_RD: begin
				rec_raddr = rc_last[RIW-1:0]; state_d = ST_F_CHK;
			end
			ST_F_CHK: begin
				if (rec_rd.released && rec_end == {1'b0, heap_top_q}) begin
					heap_top_d = rec_rd.start;
					heap_left_d = hra_pkg::sat_add(heap_left_q, rec_rd.size);
					rc_d = rc_last;
				end
				state_d = ST_FINISH;
			end
			ST_RE_RD: begin
				if (jr_inc >= rc_q) begin
					rc_d = rc_last; state_d = ret_q;
				end else begin
					rec_raddr = jr_inc[RIW-1:0]; state_d = ST_RE_WR;
				end
			end
			ST_RE_WR: begin
				rec_we = 1'b1; rec_waddr = jr_q[RIW-1:0]; rec_wdata = rec_rd;
				jr_d = jr_inc; state_d = ST_RE_RD;
			end
			ST_FE_RD: begin
				if (jf_inc >= fc_q) begin
					fc_d = fc_q - FCW'(1); state_d = ret_q;
				end else begin
					frag_raddr = jf_inc[FIW-1:0]; state_d = ST_FE_WR;
				end
			end
			ST_FE_WR: begin
				frag_we = 1'b1; frag_waddr = jf_q[FIW-1:0]; frag_wdata = frag_rd;
				jf_d = jf_inc; state_d = ST_FE_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; ret_q <= ST_IDLE;
			rc_q <= '0; fc_q <= '0;
			heap_base_q <= '0; heap_bytes_q <= '0; store_base_q <= '0; store_bytes_q <= '0;
			heap_top_q <= '0; heap_left_q <= '0; store_top_q <= '0; store_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d; ret_q <= ret_d;
			rc_q <= rc_d; fc_q <= fc_d;
			heap_base_q <= heap_base_d; heap_bytes_q <= heap_bytes_d;
			store_base_q <= store_base_d; store_bytes_q <= store_bytes_d;
			heap_top_q <= heap_top_d; heap_left_q <= heap_left_d;
			store_top_q <= store_top_d; store_left_q <= store_left_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; s_q <= s_d; c_q <= c_d; jr_q <= jr_d; jf_q <= jf_d;
		op_q <= op_d; bytes_q <= bytes_d; addr_q <= addr_d; wh_q <= wh_d; ch_q <= ch_d;
		fs_start_q <= fs_start_d; fs_size_q <= fs_size_d;
		res_addr_q <= res_addr_d; res_bytes_q <= res_bytes_d; res_status_q <= res_status_d;
		out_data_q <= out_data_d;
	end

	a_rc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= RCW'(MAX_RECORDS)) else $error("record count beyond table depth");

	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FCW'(MAX_FRAGMENTS)) else $error("fragment count beyond table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE)) else $error("accepted word not taken up");

	a_rec_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> (RCW'(rec_waddr) <= rc_q)) else $error("record write past the table end");

	a_frag_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		frag_we |-> (FCW'(frag_waddr) <= fc_q)) else $error("fragment write past the list end");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the heap record allocator core.
// A queue of request words, filled phase by phase, feeds a clocked driver.
// The driver keeps its own copy of the record and fragment tables and works
// out the reply to each word it gets accepted. A clocked monitor compares
// each reply word with the oldest expected one. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RECORD_SLOTS   = 64;
	localparam int FRAGMENT_SLOTS = 32;
	localparam logic [15:0] LOCK_FULL = 16'hFFFF;
	localparam int CYCLE_LIMIT    = 20_000_000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	hra_pkg::in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	hra_pkg::out_word_t out_data;
	logic      cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	heap_record_allocator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the allocator state.
	logic [31:0] rec_start [RECORD_SLOTS];
	logic [31:0] rec_size  [RECORD_SLOTS];
	bit          rec_handle[RECORD_SLOTS];
	bit          rec_freed [RECORD_SLOTS];
	logic [15:0] rec_locks [RECORD_SLOTS];
	int          rec_count;
	logic [31:0] frag_start[FRAGMENT_SLOTS];
	logic [31:0] frag_size [FRAGMENT_SLOTS];
	int          frag_count;
	logic [31:0] heap_base, heap_bytes, store_base, store_bytes;
	logic [31:0] heap_top, heap_left, store_top, store_left;

	hra_pkg::in_word_t    request_fifo[$];
	hra_pkg::out_word_t   expected_replies[$];
	logic [31:0] addr_bases[$];
	int          errors;
	int          replies_seen;
	int          gap_left;
	int          send_calm, stall_calm;
	bit          force_calm;
	bit          hold_send;
	longint      cycles;

	function automatic void queue_word(hra_pkg::in_word_t w);
		request_fifo = {request_fifo, w};
	endfunction

	function automatic logic [31:0] clip_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic void drop_record(int i);
		int j;
		for (j = i; j < rec_count - 1; j++) begin
			rec_start[j]  = rec_start[j + 1];
			rec_size[j]   = rec_size[j + 1];
			rec_handle[j] = rec_handle[j + 1];
			rec_freed[j]  = rec_freed[j + 1];
			rec_locks[j]  = rec_locks[j + 1];
		end
		rec_count--;
	endfunction

	function automatic void drop_fragment(int i);
		int j;
		for (j = i; j < frag_count - 1; j++) begin
			frag_start[j] = frag_start[j + 1];
			frag_size[j]  = frag_size[j + 1];
		end
		frag_count--;
	endfunction

	function automatic void add_record(logic [31:0] start, logic [31:0] size, bit handle);
		rec_start[rec_count]  = start;
		rec_size[rec_count]   = size;
		rec_handle[rec_count] = handle;
		rec_freed[rec_count]  = 1'b0;
		rec_locks[rec_count]  = '0;
		rec_count++;
	endfunction

	function automatic bit merge_pair();
		int s, c;
		logic [32:0] end_s, end_c;
		for (s = frag_count - 1; s >= 0; s--) begin
			for (c = frag_count - 1; c >= 0; c--) begin
				if (c == s)
					continue;
				end_s = {1'b0, frag_start[s]} + {1'b0, frag_size[s]};
				end_c = {1'b0, frag_start[c]} + {1'b0, frag_size[c]};
				if (end_c == {1'b0, frag_start[s]} || end_s == {1'b0, frag_start[c]}) begin
					if (frag_start[c] < frag_start[s])
						frag_start[s] = frag_start[c];
					frag_size[s] = clip_sum(frag_size[s], frag_size[c]);
					drop_fragment(c);
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic void tidy_heap();
		int i;
		for (i = rec_count - 1; i >= 0; i--) begin
			if (!rec_freed[i])
				continue;
			if (rec_size[i] == 0) begin
				drop_record(i);
			end else if (frag_count < FRAGMENT_SLOTS) begin
				frag_start[frag_count] = rec_start[i];
				frag_size[frag_count]  = rec_size[i];
				frag_count++;
				drop_record(i);
			end
		end
		while (merge_pair()) begin
		end
		for (i = frag_count - 1; i >= 0; i--) begin
			if ({1'b0, frag_start[i]} + {1'b0, frag_size[i]} == {1'b0, heap_top}) begin
				heap_top  = frag_start[i];
				heap_left = clip_sum(heap_left, frag_size[i]);
				drop_fragment(i);
			end
		end
	endfunction

	function automatic int find_live(logic [31:0] addr);
		int i;
		for (i = 0; i < rec_count; i++)
			if (rec_start[i] == addr && !rec_freed[i])
				return i;
		return -1;
	endfunction

	function automatic hra_pkg::out_word_t serve_request(hra_pkg::in_word_t w);
		hra_pkg::out_word_t r;
		logic [32:0] need, region_end;
		int i, idx, last;
		bit done;
		r = '0;
		r.status = hra_pkg::STATUS_OK;
		need = ({1'b0, w.request_bytes} + 33'd1) & ~33'd1;
		region_end = {1'b0, store_base} + {1'b0, store_bytes};
		case (w.op)
			hra_pkg::OP_ALLOC_HEAP: begin
				tidy_heap();
				if (rec_count >= RECORD_SLOTS) begin
					r.status = hra_pkg::STATUS_TABLE_FULL;
				end else begin
					done = 1'b0;
					for (i = 0; i < frag_count && !done; i++) begin
						if ({1'b0, frag_size[i]} >= need) begin
							r.block_address = frag_start[i];
							add_record(frag_start[i], need[31:0], w.want_handle);
							frag_start[i] += need[31:0];
							frag_size[i]  -= need[31:0];
							if (frag_size[i] == 0)
								drop_fragment(i);
							done = 1'b1;
						end
					end
					if (!done) begin
						if (need > {1'b0, heap_left}) begin
							r.status = hra_pkg::STATUS_NO_MEMORY;
						end else begin
							r.block_address = heap_top;
							add_record(heap_top, need[31:0], w.want_handle);
							heap_top  += need[31:0];
							heap_left -= need[31:0];
						end
					end
				end
			end
			hra_pkg::OP_ALLOC_STORE: begin
				if (rec_count >= RECORD_SLOTS) begin
					r.status = hra_pkg::STATUS_TABLE_FULL;
				end else if (need > {1'b0, store_left}) begin
					r.status = hra_pkg::STATUS_NO_MEMORY;
				end else begin
					r.block_address = store_top;
					add_record(store_top, need[31:0], w.want_handle);
					store_top  += need[31:0];
					store_left -= need[31:0];
				end
			end
			hra_pkg::OP_FREE, hra_pkg::OP_LOCK, hra_pkg::OP_UNLOCK,
			hra_pkg::OP_GET_SIZE: begin
				idx = find_live(w.target_address);
				if (w.target_address < heap_base || {1'b0, w.target_address} >= region_end) begin
					r.status = hra_pkg::STATUS_OUTSIDE;
				end else if (idx < 0) begin
					r.status = hra_pkg::STATUS_NOT_FOUND;
				end else if (w.check_handle && rec_handle[idx] != w.want_handle) begin
					r.status = hra_pkg::STATUS_HANDLE;
				end else if (w.op == hra_pkg::OP_FREE) begin
					rec_freed[idx] = 1'b1;
					last = rec_count - 1;
					if (rec_freed[last] && {1'b0, rec_start[last]} + {1'b0, rec_size[last]}
							== {1'b0, heap_top}) begin
						heap_top  = rec_start[last];
						heap_left = clip_sum(heap_left, rec_size[last]);
						rec_count--;
					end
				end else if (w.op == hra_pkg::OP_LOCK) begin
					if (rec_locks[idx] != LOCK_FULL)
						rec_locks[idx]++;
				end else if (w.op == hra_pkg::OP_UNLOCK) begin
					if (rec_locks[idx] != 0)
						rec_locks[idx]--;
					else
						r.status = hra_pkg::STATUS_NOT_LOCKED;
				end else begin
					r.block_bytes = rec_size[idx];
				end
			end
			default: r.status = hra_pkg::STATUS_NOT_FOUND;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (force_calm)
			return 0;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2)
			send_calm = 40;
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit pick_stall();
		int roll;
		if (force_calm)
			return 1'b0;
		if (stall_calm > 0) begin
			stall_calm--;
			return 1'b0;
		end
		roll = $urandom_range(0, 999);
		if (roll < 15)
			stall_calm = 60;
		if (roll < 5)
			stall_calm = -$urandom_range(10, 40);
		if (stall_calm < 0) begin
			stall_calm++;
			return 1'b1;
		end
		return roll < 300;
	endfunction

	function automatic hra_pkg::in_word_t make_word(logic [2:0] op, logic [31:0] req,
			logic [31:0] addr, bit want, bit check);
		hra_pkg::in_word_t w;
		w.op = op;
		w.request_bytes = req;
		w.target_address = addr;
		w.want_handle = want;
		w.check_handle = check;
		return w;
	endfunction

	function automatic hra_pkg::in_word_t random_word();
		int roll;
		logic [2:0] op;
		logic [31:0] req, addr;
		roll = $urandom_range(0, 99);
		if (roll < 30)      op = hra_pkg::OP_ALLOC_HEAP;
		else if (roll < 40) op = hra_pkg::OP_ALLOC_STORE;
		else if (roll < 65) op = hra_pkg::OP_FREE;
		else if (roll < 77) op = hra_pkg::OP_LOCK;
		else if (roll < 87) op = hra_pkg::OP_UNLOCK;
		else if (roll < 97) op = hra_pkg::OP_GET_SIZE;
		else                op = 3'($urandom_range(6, 7));
		roll = $urandom_range(0, 99);
		if (roll < 70)      req = $urandom_range(7, 8);
		else if (roll < 85) req = $urandom_range(0, 40);
		else if (roll < 95) req = $urandom;
		else                req = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		if ($urandom_range(0, 99) < 85)
			addr = addr_bases[$urandom_range(0, addr_bases.size() - 1)]
				+ 32'($urandom_range(0, 63) * 8);
		else
			addr = $urandom;
		return make_word(op, req, addr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d replies still due", cycles,
				expected_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Driver: predicts the reply of every accepted word, then offers the next one.
	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid)
				expected_replies = {expected_replies, serve_request(in_data)};
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_fifo.size() > 0 && !hold_send) begin
				in_data  <= request_fifo.pop_front();
				in_valid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each reply word against the oldest prediction.
	always @(posedge clk) begin
		hra_pkg::out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected reply %h", $time, out_data);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					if (out_data.block_address !== want.block_address) begin
						$display("%0t: block_address expected %h actual %h", $time,
							want.block_address, out_data.block_address);
						errors++;
					end
					if (out_data.block_bytes !== want.block_bytes) begin
						$display("%0t: block_bytes expected %h actual %h", $time,
							want.block_bytes, out_data.block_bytes);
						errors++;
					end
					if (out_data.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, out_data.status);
						errors++;
					end
				end
			end
			out_stall <= pick_stall();
		end
	end

	task automatic drain();
		while (request_fifo.size() > 0 || in_valid || expected_replies.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
	endtask

	task automatic set_regions(logic [31:0] hb, logic [31:0] hs, logic [31:0] sb,
			logic [31:0] ss);
		write_reg(hra_pkg::REG_HEAP_BASE, hb);
		write_reg(hra_pkg::REG_HEAP_BYTES, hs);
		write_reg(hra_pkg::REG_STORE_BASE, sb);
		write_reg(hra_pkg::REG_STORE_BYTES, ss);
		@(posedge clk);
		cfg_we <= 1'b0;
		heap_base  = hb; heap_top  = hb;
		heap_bytes = hs; heap_left = hs;
		store_base = sb; store_top = sb;
		store_bytes = ss; store_left = ss;
		addr_bases = {addr_bases, hb};
		addr_bases = {addr_bases, sb};
	endtask

	task automatic random_phase(int count, bit with_pause);
		int i;
		for (i = 0; i < count; i++)
			queue_word(random_word());
		if (with_pause) begin
			while (request_fifo.size() > count / 2)
				@(posedge clk);
			hold_send = 1'b1;
			while (in_valid || expected_replies.size() > 0)
				@(posedge clk);
			repeat ($urandom_range(1, 20)) @(posedge clk);
			hold_send = 1'b0;
		end
		drain();
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hra_pkg::REG_HEAP_BASE;
		cfg_data = '0;
		errors = 0;
		replies_seen = 0;
		gap_left = 0;
		send_calm = 0;
		stall_calm = 0;
		force_calm = 1'b1;
		hold_send = 1'b0;
		cycles = 0;
		rec_count = 0;
		frag_count = 0;
		heap_base = '0; heap_bytes = '0; store_base = '0; store_bytes = '0;
		heap_top = '0; heap_left = '0; store_top = '0; store_left = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Lock counting on a lone storage record.
		set_regions(32'h0000_4000, 32'h0000_1000, 32'h0000_8000, 32'h0000_0100);
		queue_word(make_word(hra_pkg::OP_ALLOC_STORE, 32'd8, '0, 1'b0, 1'b0));
		for (i = 0; i < 40; i++)
			queue_word(make_word(hra_pkg::OP_LOCK, '0, 32'h0000_8000, 1'b1, 1'b0));
		queue_word(make_word(hra_pkg::OP_UNLOCK, '0, 32'h0000_8000, 1'b0, 1'b0));
		drain();
		force_calm = 1'b0;

		// Fill the record table, then overfill the fragment table.
		for (i = 0; i < 64; i++)
			queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd8, '0, i[0], 1'b0));
		for (i = 0; i < 32; i++)
			queue_word(make_word(hra_pkg::OP_FREE, '0, 32'h4000 + 32'(16 * i), 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd9, '0, 1'b0, 1'b0));
		for (i = 0; i < 5; i++)
			queue_word(make_word(hra_pkg::OP_FREE, '0, 32'h4008 + 32'(16 * i), 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd9, '0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd8, '0, 1'b1, 1'b0));
		drain();

		// Extreme region settings and the basic operations.
		set_regions(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF);
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd0, '0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd1, '0, 1'b1, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'hFFFF_FFFF, '0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'hFFFF_FFFE, '0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_STORE, 32'd8, '0, 1'b1, 1'b0));
		queue_word(make_word(hra_pkg::OP_ALLOC_STORE, 32'hFFFF_FFFF, '0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_GET_SIZE, '0, 32'h0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_LOCK, '0, 32'h0, 1'b0, 1'b1));
		queue_word(make_word(hra_pkg::OP_LOCK, '0, 32'h0, 1'b1, 1'b1));
		queue_word(make_word(hra_pkg::OP_UNLOCK, '0, 32'h0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_UNLOCK, '0, 32'h0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_FREE, '0, 32'h0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_GET_SIZE, '0, 32'h0, 1'b1, 1'b1));
		queue_word(make_word(hra_pkg::OP_FREE, '0, 32'h0, 1'b1, 1'b1));
		queue_word(make_word(hra_pkg::OP_ALLOC_HEAP, 32'd4, '0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_GET_SIZE, '0, 32'hFFFF_FF00, 1'b1, 1'b1));
		queue_word(make_word(hra_pkg::OP_GET_SIZE, '0, 32'h0000_1234, 1'b0, 1'b0));
		drain();
		random_phase(350, 1'b0);

		// Empty heap: nonzero heap allocations can only be met from fragments or reclaimed space.
		set_regions(32'h0000_4000, 32'h0, 32'h0000_8000, 32'h0000_0080);
		queue_word(make_word(hra_pkg::OP_LOCK, '0, 32'h0, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_LOCK, '0, 32'h0000_8080, 1'b0, 1'b0));
		queue_word(make_word(hra_pkg::OP_LOCK, '0, 32'h0000_807F, 1'b0, 1'b0));
		queue_word(make_word(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
		queue_word(make_word(3'd7, 32'h0, 32'h0000_4000, 1'b0, 1'b0));
		random_phase(350, 1'b1);

		set_regions(32'hFFFF_FFFF, 32'h0000_0010, 32'h0, 32'h0);
		random_phase(100, 1'b0);

		set_regions(32'h0000_2000, 32'h0000_3000, 32'h0000_6000, 32'h0000_4000);
		random_phase(430, 1'b1);

		$display("Covered lock counting, full record and fragment tables, every op");
		$display("and region extremes; %0d replies checked, %0d mismatches.",
			replies_seen, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
